// File: rtl/morphing_oscillator_waveshaper_unit_defines.svh
// Assertion macros for the morphing oscillator waveshaper unit.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef MORPHING_OSCILLATOR_WAVESHAPER_UNIT_DEFINES_SVH
`define MORPHING_OSCILLATOR_WAVESHAPER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// clocked assertion, disabled while reset is asserted
`define MOWS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mows assertion failed");
// clocked assertion, always armed
`define MOWS_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("mows assertion failed");
`else
`define MOWS_ASSERT(lbl, clk, rst_n, prop)
`define MOWS_ASSERT_NR(lbl, clk, prop)
`endif

`endif

// File: rtl/mows_pkg.sv
// Shared types and constants of the morphing oscillator waveshaper unit.
// No dependencies; imported by every module of the block.
package mows_pkg;

    typedef struct packed {
        logic en;
        logic valid;
    } t_pipe_ctl;

    typedef enum logic [0:0] {
        REG_SHAPE_EXP = 1'b0
    } t_reg_idx;

    localparam int unsigned SAW_BITS  = 16;
    localparam int unsigned EXP_BITS  = 16;
    localparam int unsigned FRAC_BITS = 24;
    localparam int unsigned EXP_TERMS = 8;

    localparam logic [EXP_BITS-1:0] SHAPE_EXP_RESET = 16'd4096;

    localparam logic [30:0] ONE30   = 31'h4000_0000;
    localparam logic [30:0] SIN_C9  = 31'd172272;
    localparam logic [30:0] SIN_COEF [4] = '{31'd5026995, 31'd85569306,
                                             31'd693598669, 31'd1686629713};
    localparam logic [29:0] LN2_Q30 = 30'd744261118;

endpackage

// File: rtl/mows_div.sv
// Restoring divider pipeline, one quotient bit per stage.
// Depends on mows_pkg for the pipeline control struct.
module mows_div #(
    parameter int unsigned NW = 41,
    parameter int unsigned DW = 17,
    parameter int unsigned QW = 23,
    parameter int unsigned SW = 18
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mows_pkg::t_pipe_ctl i_ctl,
    input  logic [NW-1:0]      i_num,
    input  logic [DW-1:0]      i_den,
    input  logic [SW-1:0]      i_side,
    output logic               o_valid,
    output logic [QW-1:0]      o_quo,
    output logic [SW-1:0]      o_side
);
    import mows_pkg::*;

    logic          r_valid [QW];
    logic [NW-1:0] r_rem   [QW];
    logic [DW-1:0] r_den   [QW];
    logic [QW-1:0] r_quo   [QW];
    logic [SW-1:0] r_side  [QW];

    genvar j;
    for (j = 0; j < QW; j++) begin : g_stage
        localparam int unsigned B = QW - 1 - j;
        logic          v_in;
        logic [NW-1:0] rem_in;
        logic [NW-1:0] den_sh;
        logic [NW-1:0] rem_n;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [QW-1:0] quo_n;
        logic [SW-1:0] side_in;
        logic          ge;

        if (j == 0) begin : g_first
            assign v_in    = i_ctl.valid;
            assign rem_in  = i_num;
            assign den_in  = i_den;
            assign quo_in  = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_valid[j-1];
            assign rem_in  = r_rem[j-1];
            assign den_in  = r_den[j-1];
            assign quo_in  = r_quo[j-1];
            assign side_in = r_side[j-1];
        end

        // trial subtract of the divisor aligned to this quotient bit
        assign den_sh = NW'(den_in) << B;
        assign ge     = rem_in >= den_sh;
        assign rem_n  = ge ? rem_in - den_sh : rem_in;
        assign quo_n  = quo_in | (QW'(ge) << B);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j] <= 1'b0;
            end else if (i_ctl.en) begin
                r_valid[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem[j]  <= rem_n;
                r_den[j]  <= den_in;
                r_quo[j]  <= quo_n;
                r_side[j] <= side_in;
            end
        end
    end

    assign o_valid = r_valid[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

`include "morphing_oscillator_waveshaper_unit_defines.svh"

    // quotient must fit in QW bits
    `MOWS_ASSERT(a_div_range, i_clk, i_rst_n, (i_ctl.en && i_ctl.valid) |-> ((i_num >> QW) < NW'(i_den)))

endmodule

// File: rtl/mows_pow.sv
// Power pipeline: -log2 by repeated squaring, scale by exponent, 2^-y by series.
// Depends on mows_pkg for constants and the pipeline control struct.
module mows_pow (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mows_pkg::t_pipe_ctl          i_ctl,
    input  logic [30:0]                  i_mag,
    input  logic                         i_neg,
    input  logic [mows_pkg::EXP_BITS-1:0] i_exp,
    output logic                         o_valid,
    output logic [30:0]                  o_pow,
    output logic                         o_neg
);
    import mows_pkg::*;

    typedef struct packed {
        logic [4:0] sh;
        logic       zero;
        logic       neg;
    } t_lg_side;

    typedef struct packed {
        logic [29:0] v;
        logic [8:0]  k;
        logic        zero;
        logic        neg;
    } t_ex_side;

    // normalize: leading one position
    logic [4:0]  w_sh;
    logic        r_n0_valid;
    logic [30:0] r_n0_mag;
    t_lg_side    r_n0_side;

    always_comb begin
        w_sh = 5'd30;
        for (int i = 0; i < 31; i++) begin
            if (i_mag[i]) begin
                w_sh = 5'(30 - i);
            end
        end
    end

    logic        r_n1_valid;
    logic [30:0] r_n1_z;
    t_lg_side    r_n1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n0_valid <= 1'b0;
            r_n1_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_n0_valid <= i_ctl.valid;
            r_n1_valid <= r_n0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_n0_mag       <= i_mag;
            r_n0_side.sh   <= w_sh;
            r_n0_side.zero <= (i_mag == '0);
            r_n0_side.neg  <= i_neg;
            r_n1_z         <= r_n0_mag << r_n0_side.sh;
            r_n1_side      <= r_n0_side;
        end
    end

    // fraction bits of the log, one squaring per stage
    logic                 r_lg_valid [FRAC_BITS];
    logic [30:0]          r_lg_z     [FRAC_BITS];
    logic [FRAC_BITS-1:0] r_lg_frac  [FRAC_BITS];
    t_lg_side             r_lg_side  [FRAC_BITS];

    genvar i;
    for (i = 0; i < FRAC_BITS; i++) begin : g_log
        logic                 v_in;
        logic [30:0]          z_in;
        logic [FRAC_BITS-1:0] f_in;
        t_lg_side             s_in;
        logic [61:0]          sq;
        logic [31:0]          top;

        if (i == 0) begin : g_first
            assign v_in = r_n1_valid;
            assign z_in = r_n1_z;
            assign f_in = '0;
            assign s_in = r_n1_side;
        end else begin : g_next
            assign v_in = r_lg_valid[i-1];
            assign z_in = r_lg_z[i-1];
            assign f_in = r_lg_frac[i-1];
            assign s_in = r_lg_side[i-1];
        end

        assign sq  = 62'(z_in) * 62'(z_in);
        assign top = sq[61:30];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_lg_valid[i] <= 1'b0;
            end else if (i_ctl.en) begin
                r_lg_valid[i] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_lg_z[i]    <= top[31] ? top[31:1] : top[30:0];
                r_lg_frac[i] <= {f_in[FRAC_BITS-2:0], top[31]};
                r_lg_side[i] <= s_in;
            end
        end
    end

    // L = shift - frac, then y = e * L in Q.24, then v = frac(y) * ln2
    logic        r_l_valid;
    logic [28:0] r_l;
    t_lg_side    r_l_side;
    logic        r_y_valid;
    logic [32:0] r_y;
    t_lg_side    r_y_side;
    logic        r_v_valid;
    t_ex_side    r_v_side;
    logic [44:0] w_el;
    logic [53:0] w_gl;

    assign w_el = 45'(i_exp) * 45'(r_l);
    assign w_gl = 54'(r_y[23:0]) * 54'(LN2_Q30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_valid <= 1'b0;
            r_y_valid <= 1'b0;
            r_v_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_l_valid <= r_lg_valid[FRAC_BITS-1];
            r_y_valid <= r_l_valid;
            r_v_valid <= r_y_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_l           <= {r_lg_side[FRAC_BITS-1].sh, 24'd0}
                             - 29'(r_lg_frac[FRAC_BITS-1]);
            r_l_side      <= r_lg_side[FRAC_BITS-1];
            r_y           <= w_el[44:12];
            r_y_side      <= r_l_side;
            r_v_side.v    <= w_gl[53:24];
            r_v_side.k    <= r_y[32:24];
            r_v_side.zero <= r_y_side.zero;
            r_v_side.neg  <= r_y_side.neg;
        end
    end

    // nested series p = 1 - v*p/d, d from 8 down to 1, three stages a term
    logic        r_ta_valid [EXP_TERMS];
    logic [30:0] r_ta_x     [EXP_TERMS];
    t_ex_side    r_ta_side  [EXP_TERMS];
    logic        r_tb_valid [EXP_TERMS];
    logic [30:0] r_tb_x     [EXP_TERMS];
    logic [30:0] r_tb_q     [EXP_TERMS];
    t_ex_side    r_tb_side  [EXP_TERMS];
    logic        r_tc_valid [EXP_TERMS];
    logic [30:0] r_tc_p     [EXP_TERMS];
    t_ex_side    r_tc_side  [EXP_TERMS];

    for (i = 0; i < EXP_TERMS; i++) begin : g_exp
        localparam int unsigned D = EXP_TERMS - i;
        localparam logic [34:0] M = 35'((64'd1 << 34) / D);
        logic        v_in;
        logic [30:0] p_in;
        t_ex_side    s_in;
        logic [60:0] vp;
        logic [65:0] qm;
        logic [33:0] qd;
        logic [33:0] rem;
        logic [30:0] q;

        if (i == 0) begin : g_first
            assign v_in = r_v_valid;
            assign p_in = ONE30;
            assign s_in = r_v_side;
        end else begin : g_next
            assign v_in = r_tc_valid[i-1];
            assign p_in = r_tc_p[i-1];
            assign s_in = r_tc_side[i-1];
        end

        assign vp  = 61'(s_in.v) * 61'(p_in);
        // divide by the constant term index: reciprocal, then one correction
        assign qm  = 66'(r_ta_x[i]) * 66'(M);
        assign qd  = 34'(r_tb_q[i]) * 34'(D);
        assign rem = 34'(r_tb_x[i]) - qd;
        assign q   = (rem >= 34'(D)) ? r_tb_q[i] + 31'd1 : r_tb_q[i];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ta_valid[i] <= 1'b0;
                r_tb_valid[i] <= 1'b0;
                r_tc_valid[i] <= 1'b0;
            end else if (i_ctl.en) begin
                r_ta_valid[i] <= v_in;
                r_tb_valid[i] <= r_ta_valid[i];
                r_tc_valid[i] <= r_tb_valid[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_ta_x[i]    <= vp[60:30];
                r_ta_side[i] <= s_in;
                r_tb_x[i]    <= r_ta_x[i];
                r_tb_q[i]    <= qm[64:34];
                r_tb_side[i] <= r_ta_side[i];
                r_tc_p[i]    <= ONE30 - q;
                r_tc_side[i] <= r_tb_side[i];
            end
        end
    end

    // integer part of y shifts the result down
    logic        r_f_valid;
    logic [30:0] r_f_pow;
    logic        r_f_neg;
    logic [30:0] w_pow;
    t_ex_side    w_fs;

    assign w_fs = r_tc_side[EXP_TERMS-1];

    always_comb begin
        if (w_fs.zero) begin
            w_pow = (i_exp == '0) ? ONE30 : '0;
        end else if (w_fs.k >= 9'd31) begin
            w_pow = '0;
        end else begin
            w_pow = r_tc_p[EXP_TERMS-1] >> w_fs.k[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_f_valid <= r_tc_valid[EXP_TERMS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_f_pow <= w_pow;
            r_f_neg <= w_fs.neg;
        end
    end

    assign o_valid = r_f_valid;
    assign o_pow   = r_f_pow;
    assign o_neg   = r_f_neg;

`include "morphing_oscillator_waveshaper_unit_defines.svh"

    `MOWS_ASSERT(a_pow_range, i_clk, i_rst_n, o_valid |-> (o_pow <= ONE30))

endmodule

// File: rtl/morphing_oscillator_waveshaper_unit.sv
// Top level of the morphing oscillator waveshaper unit.
// Depends on mows_pkg, mows_div, mows_pow and the assertion macro header.
//
// Phase-distortion oscillator shaper. Each input word carries a phase
// fraction and a saw amount; the phase is warped in three pieces, a sine and
// a triangle of the warped phase are blended by the saw amount, and the
// magnitude of the blend is raised to the shape exponent with its sign put
// back. One sample word comes out for each input word, in order. The unit is
// a pipeline that takes one word every clock unless the skid entry is full:
// the warp divider spends one stage per quotient bit (PHASE_BITS-1 stages),
// and the input capture, sine, mix, log/exp power path and output register
// add 66 more. An output register and one skid entry keep the input open
// while one result waits; the whole pipeline holds when the skid entry is
// full. The shape exponent register (unsigned Q4.12, reset 1.0) sits at
// address 0 of the APB port; the user must write it only while the unit is
// idle, and the unit itself does not enforce this.
module morphing_oscillator_waveshaper_unit #(
    parameter int unsigned PHASE_BITS  = 24,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // stream in
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // phase [PHASE_BITS-1:0], saw_amount [PHASE_BITS+15:PHASE_BITS], zero pad
    input  logic [((PHASE_BITS + mows_pkg::SAW_BITS + 7) / 8) * 8 - 1:0] i_s_tdata,
    // stream out
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // sample [SAMPLE_BITS-1:0], zero pad
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] o_m_tdata,
    // config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mows_pkg::*;

    localparam int unsigned PB    = PHASE_BITS;
    localparam int unsigned SB    = SAMPLE_BITS;
    localparam int unsigned OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int unsigned CW    = PB + 20;
    localparam int unsigned NW    = PB + 17;
    localparam int unsigned DW    = 17;
    localparam int unsigned QW    = PB - 1;
    localparam int unsigned SW    = 2 + SAW_BITS;

    localparam logic [1:0] SEG_RISE = 2'd0;
    localparam logic [1:0] SEG_MID  = 2'd1;
    localparam logic [1:0] SEG_FALL = 2'd2;

    typedef struct packed {
        logic [30:0]        x;
        logic [30:0]        x2;
        logic [1:0]         quad;
        logic signed [31:0] tri_v;
        logic [15:0]        saw;
    } t_sn_side;

    // ---------------------------------------------------------------
    // config register
    // ---------------------------------------------------------------
    logic [EXP_BITS-1:0] r_shape_exp;
    logic                w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SHAPE_EXP);
    assign prdata   = (paddr[2] == REG_SHAPE_EXP) ? {16'd0, r_shape_exp} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape_exp <= SHAPE_EXP_RESET;
        end else if (w_cfg_wr) begin
            r_shape_exp <= pwdata[15:0];
        end
    end

    // ---------------------------------------------------------------
    // pipeline advance: hold everything while the skid entry is full
    // ---------------------------------------------------------------
    logic w_en;
    logic r_skid_valid;
    logic r_out_valid;

    assign w_en       = !r_skid_valid;
    assign o_s_tready = w_en;

    // capture the input word
    logic          r_w0_valid;
    logic [PB-1:0] r_w0_t;
    logic [15:0]   r_w0_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w0_valid <= 1'b0;
        end else if (w_en) begin
            r_w0_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_w0_t <= i_s_tdata[PB-1:0];
            r_w0_s <= i_s_tdata[PB +: SAW_BITS];
        end
    end

    // ---------------------------------------------------------------
    // warp: pick the segment, set up the divider
    // ---------------------------------------------------------------
    logic [DW-1:0] w_a;
    logic [DW-1:0] w_b;
    logic [CW-1:0] w_t18;
    logic [CW-1:0] w_lim0;
    logic [CW-1:0] w_lim1;
    logic [CW-1:0] w_mid_num;
    logic [CW-1:0] w_fall_num;
    logic [1:0]    w_seg;
    logic [NW-1:0] w_num;
    logic [DW-1:0] w_den;

    assign w_a        = 17'd65536 - 17'(r_w0_s);
    assign w_b        = 17'd65536 + 17'(r_w0_s);
    assign w_t18      = CW'(r_w0_t) << 18;
    assign w_lim0     = CW'(w_a) << PB;
    assign w_lim1     = (CW'(w_a) + (CW'(w_b) << 1)) << PB;
    assign w_mid_num  = (w_t18 - w_lim0) >> 2;
    assign w_fall_num = ((CW'(1) << PB) - CW'(r_w0_t)) << 16;

    always_comb begin
        if (w_t18 < w_lim0) begin
            w_seg = SEG_RISE;
            w_num = NW'(r_w0_t) << 16;
            w_den = w_a;
        end else if (w_t18 < w_lim1) begin
            w_seg = SEG_MID;
            w_num = w_mid_num[NW-1:0];
            w_den = w_b;
        end else begin
            w_seg = SEG_FALL;
            w_num = w_fall_num[NW-1:0];
            w_den = w_a;
        end
    end

    logic          w_dv_valid;
    logic [QW-1:0] w_dv_quo;
    logic [SW-1:0] w_dv_side;

    mows_div #(
        .NW (NW),
        .DW (DW),
        .QW (QW),
        .SW (SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{en: w_en, valid: r_w0_valid}),
        .i_num   (w_num),
        .i_den   (w_den),
        .i_side  ({w_seg, r_w0_s}),
        .o_valid (w_dv_valid),
        .o_quo   (w_dv_quo),
        .o_side  (w_dv_side)
    );

    // warped phase, left-aligned to 32 bits
    logic [PB-1:0] w_w;
    logic          r_u_valid;
    logic [31:0]   r_u;
    logic [15:0]   r_u_s;

    always_comb begin
        case (w_dv_side[SW-1 -: 2])
            SEG_RISE: w_w = PB'(w_dv_quo);
            SEG_MID:  w_w = PB'(w_dv_quo) + (PB'(1) << (PB - 2));
            SEG_FALL: w_w = PB'((PB + 1)'(1) << PB) - PB'(w_dv_quo);
            default:  w_w = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_valid <= 1'b0;
        end else if (w_en) begin
            r_u_valid <= w_dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_u   <= 32'(w_w) << (32 - PB);
            r_u_s <= w_dv_side[15:0];
        end
    end

    // ---------------------------------------------------------------
    // sine (quarter wave polynomial) and triangle
    // ---------------------------------------------------------------
    logic [30:0] w_rr;
    logic [33:0] w_u34;
    logic [33:0] w_tri34;
    t_sn_side    w_sn0;
    logic        r_sn0_valid;
    t_sn_side    r_sn0;
    t_sn_side    w_sn1;
    logic        r_sn1_valid;
    t_sn_side    r_sn1;
    logic [61:0] w_xx;

    assign w_rr  = {1'b0, r_u[29:0]};
    assign w_u34 = {2'b00, r_u};

    always_comb begin
        case (r_u[31:30])
            2'd0:    w_tri34 = w_u34;
            2'd1:    w_tri34 = (34'd1 << 31) - w_u34;
            2'd2:    w_tri34 = (34'd1 << 31) - w_u34;
            default: w_tri34 = w_u34 - (34'd1 << 32);
        endcase
    end

    always_comb begin
        w_sn0.x     = r_u[30] ? ONE30 - w_rr : w_rr;
        w_sn0.x2    = '0;
        w_sn0.quad  = r_u[31:30];
        w_sn0.tri_v = $signed(w_tri34[31:0]);
        w_sn0.saw   = r_u_s;
    end

    assign w_xx = 62'(r_sn0.x) * 62'(r_sn0.x);

    // carry the side fields forward with x squared filled in
    always_comb begin
        w_sn1    = r_sn0;
        w_sn1.x2 = w_xx[60:30];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sn0_valid <= 1'b0;
            r_sn1_valid <= 1'b0;
        end else if (w_en) begin
            r_sn0_valid <= r_u_valid;
            r_sn1_valid <= r_sn0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sn0 <= w_sn0;
            r_sn1 <= w_sn1;
        end
    end

    // Horner steps, one coefficient per stage
    logic        r_py_valid [4];
    logic [30:0] r_py_p     [4];
    t_sn_side    r_py_side  [4];

    genvar k;
    for (k = 0; k < 4; k++) begin : g_poly
        logic        v_in;
        logic [30:0] p_in;
        t_sn_side    s_in;
        logic [61:0] px;

        if (k == 0) begin : g_first
            assign v_in = r_sn1_valid;
            assign p_in = SIN_C9;
            assign s_in = r_sn1;
        end else begin : g_next
            assign v_in = r_py_valid[k-1];
            assign p_in = r_py_p[k-1];
            assign s_in = r_py_side[k-1];
        end

        assign px = 62'(p_in) * 62'(s_in.x2);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_py_valid[k] <= 1'b0;
            end else if (w_en) begin
                r_py_valid[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_py_p[k]    <= SIN_COEF[k] - px[60:30];
                r_py_side[k] <= s_in;
            end
        end
    end

    // final multiply by x, clamp to one, sign by half cycle
    logic               r_sn6_valid;
    logic signed [31:0] r_sn6_sin;
    logic signed [31:0] r_sn6_tri;
    logic [15:0]        r_sn6_saw;
    logic [61:0]        w_px;
    logic [31:0]        w_smag;
    t_sn_side           w_ps;

    assign w_ps   = r_py_side[3];
    assign w_px   = 62'(r_py_p[3]) * 62'(w_ps.x);
    assign w_smag = (w_px[61:30] > 32'(ONE30)) ? 32'(ONE30) : w_px[61:30];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sn6_valid <= 1'b0;
        end else if (w_en) begin
            r_sn6_valid <= r_py_valid[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sn6_sin <= w_ps.quad[1] ? -$signed(w_smag) : $signed(w_smag);
            r_sn6_tri <= w_ps.tri_v;
            r_sn6_saw <= w_ps.saw;
        end
    end

    // ---------------------------------------------------------------
    // blend: (1-s)*sin + s*tri in Q1.46, then magnitude in Q0.30
    // ---------------------------------------------------------------
    logic               r_mx0_valid;
    logic signed [50:0] r_mx0_pa;
    logic signed [50:0] r_mx0_ps;
    logic signed [50:0] w_sin_ext;
    logic signed [50:0] w_tri_ext;
    logic signed [50:0] w_a_ext;
    logic signed [50:0] w_s_ext;
    logic signed [50:0] w_m;
    logic [50:0]        w_abs;
    logic               r_mx1_valid;
    logic [30:0]        r_mx1_mag;
    logic               r_mx1_neg;

    assign w_sin_ext = {{19{r_sn6_sin[31]}}, r_sn6_sin};
    assign w_tri_ext = {{19{r_sn6_tri[31]}}, r_sn6_tri};
    assign w_a_ext   = $signed(51'(17'd65536 - 17'(r_sn6_saw)));
    assign w_s_ext   = $signed(51'(r_sn6_saw));
    assign w_m       = r_mx0_pa + r_mx0_ps;
    assign w_abs     = w_m[50] ? 51'(-w_m) : 51'(w_m);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mx0_valid <= 1'b0;
            r_mx1_valid <= 1'b0;
        end else if (w_en) begin
            r_mx0_valid <= r_sn6_valid;
            r_mx1_valid <= r_mx0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mx0_pa  <= w_a_ext * w_sin_ext;
            r_mx0_ps  <= w_s_ext * w_tri_ext;
            r_mx1_mag <= w_abs[46:16];
            r_mx1_neg <= w_m[50];
        end
    end

    // ---------------------------------------------------------------
    // power curve
    // ---------------------------------------------------------------
    logic        w_pw_valid;
    logic [30:0] w_pw;
    logic        w_pw_neg;

    mows_pow u_pow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{en: w_en, valid: r_mx1_valid}),
        .i_mag   (r_mx1_mag),
        .i_neg   (r_mx1_neg),
        .i_exp   (r_shape_exp),
        .o_valid (w_pw_valid),
        .o_pow   (w_pw),
        .o_neg   (w_pw_neg)
    );

    // round half up to SAMPLE_BITS-1 fraction bits, restore sign, saturate +1
    logic [SB+30:0] w_rnd;
    logic [SB-1:0]  w_val;
    logic [SB-1:0]  w_smax;
    logic [SB-1:0]  w_sample;

    assign w_rnd    = ((SB + 31)'(w_pw) << (SB - 1)) + ((SB + 31)'(1) << 29);
    assign w_val    = w_rnd[30 +: SB];
    assign w_smax   = (SB'(1) << (SB - 1)) - SB'(1);
    assign w_sample = w_pw_neg ? SB'(-w_val) : ((w_val > w_smax) ? w_smax : w_val);

    // ---------------------------------------------------------------
    // output register with one skid entry
    // ---------------------------------------------------------------
    logic [SB-1:0] r_out_data;
    logic [SB-1:0] r_skid_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_m_tready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || i_m_tready) begin
            r_out_valid <= w_pw_valid;
        end else if (w_pw_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_m_tready) begin
                r_out_data <= r_skid_data;
            end
        end else if (!r_out_valid || i_m_tready) begin
            r_out_data <= w_sample;
        end else begin
            r_skid_data <= w_sample;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'(r_out_data);

`include "morphing_oscillator_waveshaper_unit_defines.svh"

    `MOWS_ASSERT(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid)
    `MOWS_ASSERT(a_skid_fill_on_stall, i_clk, i_rst_n, $rose(r_skid_valid) |-> $past(r_out_valid && !i_m_tready))
    `MOWS_ASSERT(a_cfg_write, i_clk, i_rst_n, (i_rst_n && w_cfg_wr) |=> (r_shape_exp == $past(pwdata[15:0])))

endmodule

// File: tb/sv/morphing_oscillator_waveshaper_unit_tb.sv
// Self-checking testbench for the morphing oscillator waveshaper unit.
// Depends on mows_pkg and the unit's RTL; predicts every sample internally.
module morphing_oscillator_waveshaper_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mows_pkg::*;

    localparam int unsigned PB = 24;
    localparam int unsigned SB = 16;
    localparam int unsigned DRAIN_CYCLES = 200;
    localparam int unsigned WATCHDOG_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;

    // expected samples, oldest first
    logic [SB-1:0] sample_q[$];
    logic [15:0]   exp_shadow;
    int unsigned   n_fail, n_checked, n_sent, idle_cycles;
    bit            hold_off;
    bit            burst_mode;

    morphing_oscillator_waveshaper_unit #(.PHASE_BITS(PB), .SAMPLE_BITS(SB)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------
    // sine of quarter-wave-folded phase, Taylor polynomial through x^9, Q1.30
    function automatic longint sin_q30(logic [31:0] u);
        logic [1:0]  quad;
        logic [63:0] r, x, x2, p, s;
        begin
            quad = u[31:30];
            r = {34'd0, u[29:0]};
            x = quad[0] ? (64'd1 << 30) - r : r;
            x2 = (x * x) >> 30;
            p = 64'd172272;
            p = 64'd5026995 - ((p * x2) >> 30);
            p = 64'd85569306 - ((p * x2) >> 30);
            p = 64'd693598669 - ((p * x2) >> 30);
            p = 64'd1686629713 - ((p * x2) >> 30);
            s = (p * x) >> 30;
            if (s > (64'd1 << 30)) s = 64'd1 << 30;
            return quad[1] ? -longint'(s) : longint'(s);
        end
    endfunction

    function automatic longint tri_q30(logic [31:0] u);
        longint v;
        begin
            v = longint'({32'd0, u});
            if (v < (64'sd1 <<< 30)) return v;
            if (v < (64'sd3 <<< 30)) return (64'sd1 <<< 31) - v;
            return v - (64'sd1 <<< 32);
        end
    endfunction

    // -log2 of a Q0.30 magnitude, in Q.24
    function automatic logic [63:0] neg_log2(logic [63:0] x);
        int unsigned n;
        logic [63:0] z, frac;
        begin
            n = 30;
            frac = 0;
            while (n > 0 && x[n] == 1'b0) n--;
            z = x << (30 - n);
            for (int i = 0; i < 24; i++) begin
                z = (z * z) >> 30;
                frac = frac << 1;
                if (z >= (64'd1 << 31)) begin
                    z = z >> 1;
                    frac[0] = 1'b1;
                end
            end
            return (64'(30 - n) << 24) - frac;
        end
    endfunction

    // 2^-y, y in Q.24, result Q0.30
    function automatic logic [63:0] exp2_neg(logic [63:0] y);
        logic [63:0] k, v, p;
        begin
            k = y >> 24;
            v = ((y & 64'hFF_FFFF) * 64'd744261118) >> 24;
            p = 64'd1 << 30;
            for (int d = 8; d >= 1; d--)
                p = (64'd1 << 30) - ((v * p) >> 30) / d;
            if (k >= 31) return 0;
            return p >> k;
        end
    endfunction

    function automatic logic [SB-1:0] shaped_sample(logic [PB-1:0] ph, logic [15:0] saw,
                                                    logic [15:0] e);
        logic [63:0] t, s, a, b, t18, w, mag, r, val, one;
        logic [31:0] u;
        longint m;
        bit neg;
        begin
            one = 64'd1 << PB;
            t = 64'(ph);
            s = 64'(saw);
            a = 65536 - s;
            b = 65536 + s;
            t18 = t << 18;
            if (t18 < (a << PB))
                w = (t << 16) / a;
            else if (t18 < ((a + 2 * b) << PB))
                w = (t18 - (a << PB)) / (4 * b) + one / 4;
            else
                w = one - ((one - t) << 16) / a;
            u = 32'(w << (32 - PB));
            m = longint'(a) * sin_q30(u) + longint'(s) * tri_q30(u);
            neg = m < 0;
            mag = 64'(neg ? -m : m) >> 16;
            if (mag == 0)
                r = (e != 0) ? 64'd0 : (64'd1 << 30);
            else
                r = exp2_neg((64'(e) * neg_log2(mag)) >> 12);
            val = ((r << (SB - 1)) + (64'd1 << 29)) >> 30;
            if (neg) return SB'((64'd1 << SB) - val);
            return (val > ((64'd1 << (SB - 1)) - 1)) ? SB'((1 << (SB - 1)) - 1) : SB'(val);
        end
    endfunction

    // ---------------- driving ----------------
    task automatic send_word(logic [PB-1:0] ph, logic [15:0] saw);
        // single words get a gap before them; bursts run back to back
        if (!burst_mode || $urandom_range(0, 15) == 0) begin
            burst_mode = $urandom_range(0, 3) != 0;
            if (!burst_mode || $urandom_range(0, 2) == 0) begin
                i_s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {8'h00, saw, ph};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sample_q.push_back(shaped_sample(ph, saw, exp_shadow));
        n_sent++;
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sample_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write the shape exponent over APB; only called while the unit is idle
    task automatic write_exponent(logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 3'(REG_SHAPE_EXP) << 2;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        exp_shadow = value[15:0];
        @(posedge i_clk);
    endtask

    // ---------------- tests ----------------
    task automatic test_directed();
        logic [PB-1:0] ph_list[12];
        logic [15:0]   saw_list[5];
        ph_list = '{24'h000000, 24'hFFFFFF, 24'h400000, 24'h800000, 24'hC00000,
                    24'h3FFFFF, 24'h7FFFFF, 24'h000001, 24'h200000, 24'hE00000,
                    24'hAAAAAA, 24'h555555};
        saw_list = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'h5555};
        for (int i = 0; i < 12; i++)
            send_word(ph_list[i], saw_list[i % 5]);
        // segment boundaries for a fixed saw amount
        send_word(24'h300000, 16'h4000);
        send_word(24'hD00000, 16'h4000);
        drain();
    endtask

    task automatic test_exponent_sweep();
        logic [31:0] e_list[6];
        e_list = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_2000,
                   32'hABCD_0800, 32'h0000_1000};
        for (int k = 0; k < 6; k++) begin
            write_exponent(e_list[k]);
            // zero magnitude and full scale under each exponent
            send_word(24'h000000, 16'h0000);
            send_word(24'h800000, 16'h0000);
            send_word(24'h400000, 16'h0000);
            send_word(24'hC00000, 16'hFFFF);
            for (int i = 0; i < 120; i++)
                send_word(PB'($urandom), 16'($urandom));
            drain();
        end
    endtask

    task automatic test_backpressure();
        // receiver stalls for a long stretch while words keep coming
        hold_off = 1'b1;
        for (int i = 0; i < 100; i++)
            send_word(PB'($urandom), ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'h0000);
        drain();
    endtask

    task automatic test_random();
        write_exponent(32'($urandom_range(0, 16'hFFFF)));
        for (int i = 0; i < 100; i++)
            send_word(PB'($urandom), 16'($urandom));
        drain();
        write_exponent(32'h0000_1000);
    endtask

    // ---------------- receiver, checker, watchdog ----------------
    initial begin
        int unsigned hold_count;
        i_m_tready <= 1'b0;
        hold_count = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                // long stall counted here, then release
                i_m_tready <= 1'b0;
                hold_count++;
                if (hold_count >= 300) begin
                    hold_off = 1'b0;
                    hold_count = 0;
                end
            end else if ((n_sent / 64) % 3 == 0) begin
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (sample_q.size() == 0) begin
                $display("%0t: unexpected sample, expected none, actual %h", $time,
                         o_m_tdata);
                n_fail++;
            end else begin
                if (o_m_tdata[SB-1:0] !== sample_q[0]) begin
                    $display("%0t: sample mismatch, expected %h, actual %h", $time,
                             sample_q[0], o_m_tdata[SB-1:0]);
                    n_fail++;
                end
                void'(sample_q.pop_front());
                n_checked++;
            end
        end
    end

    // count cycles without any accepted word
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("morphing_oscillator_waveshaper_unit regression: fail");
            $finish;
        end
    end

    initial begin
        n_fail = 0; n_checked = 0; n_sent = 0;
        hold_off = 1'b0; burst_mode = 1'b0;
        exp_shadow = SHAPE_EXP_RESET;
        i_rst_n <= 1'b0;
        i_s_tvalid <= 1'b0; i_s_tdata <= '0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_exponent_sweep();
        test_backpressure();
        test_random();
        if (sample_q.size() != 0) begin
            $display("%0t: %0d samples never arrived", $time, sample_q.size());
            n_fail++;
        end
        $display("Sent %0d words over 8 exponent settings, checked %0d samples.",
                 n_sent, n_checked);
        if (n_fail == 0)
            $display("morphing_oscillator_waveshaper_unit regression: pass");
        else
            $display("morphing_oscillator_waveshaper_unit regression: fail");
        $finish;
    end
endmodule
